// ===== hdl/eqvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eqvp_pkg
// Shared constants and types for the Euler-to-quaternion voxel placer.
// ----------------------------------------------------------------------------
package eqvp_pkg;

    localparam int WORK_W     = 36;  // Q.30 working width, range about +-32
    localparam int ATAN_COUNT = 24;

    localparam logic signed [WORK_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [WORK_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [WORK_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [WORK_W-1:0] GAIN_Q30    = 36'sd652032874;

    typedef enum logic [2:0] {
        REG_GRID_COLS    = 3'd0,
        REG_GRID_ROWS    = 3'd1,
        REG_GRID_SLICES  = 3'd2,
        REG_SLICE_NUMBER = 3'd3,
        REG_SCAN_COLS    = 3'd4,
        REG_SCAN_ROWS    = 3'd5
    } reg_index_t;

    typedef logic signed [WORK_W-1:0] work_t;

    function automatic work_t atan_q30(input int idx);
        work_t r;
        case (idx)
            0: r = 36'sd843314856;   1: r = 36'sd497837829;
            2: r = 36'sd263043836;   3: r = 36'sd133525158;
            4: r = 36'sd67021686;    5: r = 36'sd33543515;
            6: r = 36'sd16775850;    7: r = 36'sd8388437;
            8: r = 36'sd4194282;     9: r = 36'sd2097149;
            10: r = 36'sd1048575;    11: r = 36'sd524287;
            12: r = 36'sd262143;     13: r = 36'sd131071;
            14: r = 36'sd65535;      15: r = 36'sd32767;
            16: r = 36'sd16383;      17: r = 36'sd8191;
            18: r = 36'sd4095;       19: r = 36'sd2047;
            20: r = 36'sd1023;       21: r = 36'sd511;
            22: r = 36'sd255;        23: r = 36'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/eqvp_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eqvp_cordic
// Pipelined sine/cosine of a Q.30 half angle: range reduction in two
// registered steps, then one registered CORDIC rotation per stage.
// All stages advance together on en.
// ----------------------------------------------------------------------------
module eqvp_cordic
    import eqvp_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire         aclk,
    input  wire         en,
    input  work_t       angle,
    output work_t       sin_out,
    output work_t       cos_out
);

    localparam int N = (STAGES < ATAN_COUNT) ? STAGES : ATAN_COUNT;

    // Reduction step one: truncating remainder by 2*pi. The half angle lies
    // within (-4*pi, 4*pi), so at most three multiples are removed.
    work_t rem_reg, rem_next;
    always_comb begin
        work_t a;
        a = (angle < 0) ? -angle : angle;
        if (a >= 3 * TWO_PI_Q30)      a = a - 3 * TWO_PI_Q30;
        else if (a >= 2 * TWO_PI_Q30) a = a - 2 * TWO_PI_Q30;
        else if (a >= TWO_PI_Q30)     a = a - TWO_PI_Q30;
        rem_next = (angle < 0) ? -a : a;
    end

    // Reduction step two: into [-pi, pi], then fold into [-pi/2, pi/2].
    work_t z0_reg, z0_next;
    logic  neg0_reg, neg0_next;
    always_comb begin
        work_t z;
        z = rem_reg;
        if (z > PI_Q30)  z = z - TWO_PI_Q30;
        if (z < -PI_Q30) z = z + TWO_PI_Q30;
        neg0_next = 1'b0;
        if (z > HALF_PI_Q30) begin
            z = PI_Q30 - z;
            neg0_next = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = -PI_Q30 - z;
            neg0_next = 1'b1;
        end
        z0_next = z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            z0_reg   <= z0_next;
            neg0_reg <= neg0_next;
        end
    end

    work_t x_reg [N+1];
    work_t y_reg [N+1];
    work_t z_reg [N+1];
    logic  neg_reg [N+1];

    always_comb begin
        x_reg[0]   = GAIN_Q30;
        y_reg[0]   = '0;
        z_reg[0]   = z0_reg;
        neg_reg[0] = neg0_reg;
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        work_t x_next, y_next, z_next;
        always_comb begin
            work_t dx, dy;
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (z_reg[i] >= 0) begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_q30(i);
            end else begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_q30(i);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign sin_out = y_reg[N];
    assign cos_out = neg_reg[N] ? -x_reg[N] : x_reg[N];

endmodule
`default_nettype wire

// ===== hdl/eqvp_quat_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eqvp_quat_mul
// Product of two Q.30 trig values, rounded to Q.16 and saturated to +-1.
// The 32x32 product is registered before rounding.
// ----------------------------------------------------------------------------
module eqvp_quat_mul
    import eqvp_pkg::*;
(
    input  wire                aclk,
    input  wire                en,
    input  work_t              a,
    input  work_t              b,
    output logic signed [17:0] q
);

    // Trig values stay within +-1.7 in Q.30, so 32 bits carry them.
    logic signed [63:0] prod_reg;
    logic signed [17:0] q_reg;
    logic signed [63:0] rnd;

    always_comb rnd = (prod_reg + (64'sd1 <<< 43)) >>> 44;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 64'($signed(a[31:0])) * 64'($signed(b[31:0]));
            if (rnd > 64'sd65536)       q_reg <= 18'sd65536;
            else if (rnd < -64'sd65536) q_reg <= -18'sd65536;
            else                        q_reg <= rnd[17:0];
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== hdl/euler_to_quaternion_voxel_placer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_voxel_placer
// Bunge Euler angles to quaternion parts, with voxel address placement.
// ----------------------------------------------------------------------------
// The block takes one scan point per transaction and returns one result
// transaction per point, in order. It accepts a new point every clock cycle
// while the output is not stalled; a point passes through two range
// reduction stages, one stage per CORDIC rotation, two multiply and rounding
// stages and one output register. The whole pipeline advances together
// whenever the output register is empty or being read, so a stall at the
// output holds every stage in place. Grid registers are written through the
// configuration channel, clamp to MAX_DIM, and should only be changed while
// no point is in flight.
module euler_to_quaternion_voxel_placer
    import eqvp_pkg::*;
#(
    parameter int MAX_DIM         = 4095,
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int TRIG_STAGES     = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // tdata: angle_phi1[18:0], angle_cap_phi[37:19], angle_phi2[56:38],
    //        scan_col[68:57], scan_row[80:69], zero fill [87:81]
    input  wire  [87:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: voxel_address[35:0], out_of_grid[36], quat_one[54:37],
    //        quat_two[72:55], quat_three[90:73], quat_four[108:91],
    //        zero fill [111:109]
    output logic [111:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire  [2:0]  cfg_index,
    input  wire  [11:0] cfg_data,
    input  wire         cfg_valid,
    output logic        cfg_ready
);

    localparam int NCOR = (TRIG_STAGES < ATAN_COUNT) ? TRIG_STAGES : ATAN_COUNT;
    localparam int LAT  = NCOR + 4;     // stages before the output register
    localparam int SHIFT = 30 - ANGLE_FRAC_BITS - 1;
    localparam logic [11:0] MAX_V = 12'(MAX_DIM > 4095 ? 4095 : MAX_DIM);

    // Configuration registers.
    logic [11:0] grid_cols_reg, grid_rows_reg, grid_slices_reg;
    logic [11:0] slice_number_reg, scan_cols_reg, scan_rows_reg;
    logic [11:0] cfg_v;

    assign cfg_ready = 1'b1;
    assign cfg_v = (cfg_data > MAX_V) ? MAX_V : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg    <= 12'd1;
            grid_rows_reg    <= 12'd1;
            grid_slices_reg  <= 12'd1;
            slice_number_reg <= 12'd0;
            scan_cols_reg    <= 12'd1;
            scan_rows_reg    <= 12'd1;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_GRID_COLS:    grid_cols_reg    <= cfg_v;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_v;
                REG_GRID_SLICES:  grid_slices_reg  <= cfg_v;
                REG_SLICE_NUMBER: slice_number_reg <= cfg_v;
                REG_SCAN_COLS:    scan_cols_reg    <= cfg_v;
                REG_SCAN_ROWS:    scan_rows_reg    <= cfg_v;
                default: ;
            endcase
        end
    end

    // Pipeline advance: the output register is free or being drained.
    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end else if (en) begin
            vld_reg  <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid <= vld_reg[LAT-1];
        end
    end

    // Half angles in Q.30.
    logic [18:0] p1, pc, p2;
    work_t a_phi, a_dif, a_sum;
    assign p1 = s_tdata[18:0];
    assign pc = s_tdata[37:19];
    assign p2 = s_tdata[56:38];
    assign a_phi = work_t'({17'd0, pc}) <<< SHIFT;
    assign a_dif = (work_t'({17'd0, p1}) - work_t'({17'd0, p2})) <<< SHIFT;
    assign a_sum = (work_t'({17'd0, p1}) + work_t'({17'd0, p2})) <<< SHIFT;

    work_t s_w, c_w, s1_w, c1_w, s2_w, c2_w;
    eqvp_cordic #(.STAGES(TRIG_STAGES)) u_cor_phi (
        .aclk(aclk), .en(en), .angle(a_phi), .sin_out(s_w), .cos_out(c_w));
    eqvp_cordic #(.STAGES(TRIG_STAGES)) u_cor_dif (
        .aclk(aclk), .en(en), .angle(a_dif), .sin_out(s1_w), .cos_out(c1_w));
    eqvp_cordic #(.STAGES(TRIG_STAGES)) u_cor_sum (
        .aclk(aclk), .en(en), .angle(a_sum), .sin_out(s2_w), .cos_out(c2_w));

    logic signed [17:0] q1, q2, q3, q4;
    eqvp_quat_mul u_q1 (.aclk(aclk), .en(en), .a(s_w), .b(c1_w), .q(q1));
    eqvp_quat_mul u_q2 (.aclk(aclk), .en(en), .a(s_w), .b(s1_w), .q(q2));
    eqvp_quat_mul u_q3 (.aclk(aclk), .en(en), .a(c_w), .b(s2_w), .q(q3));
    eqvp_quat_mul u_q4 (.aclk(aclk), .en(en), .a(c_w), .b(c2_w), .q(q4));

    // Voxel placement, computed through the coordinate, product, plane and
    // address registers, then delayed to line up with the quaternion parts.
    logic signed [13:0] xs, ys, zs;
    logic signed [13:0] x_reg, y_reg, z_reg;
    logic               out_reg;
    logic [23:0]        zgc_reg, ygc_reg;
    logic [11:0]        xa_reg, xa2_reg;
    logic [35:0]        plane_reg;
    logic [35:0]        addr_reg;
    logic               out2_reg, out3_reg;
    logic signed [12:0] dc, dr;

    assign dc = $signed({1'b0, grid_cols_reg}) - $signed({1'b0, scan_cols_reg});
    assign dr = $signed({1'b0, grid_rows_reg}) - $signed({1'b0, scan_rows_reg});
    // Division by two truncating toward zero.
    assign xs = 14'($signed({2'b0, s_tdata[68:57]})) +
                14'((dc + $signed({12'd0, dc < 0})) >>> 1);
    assign ys = 14'($signed({2'b0, s_tdata[80:69]})) +
                14'((dr + $signed({12'd0, dr < 0})) >>> 1);
    assign zs = $signed({2'b0, grid_slices_reg}) - 14'sd1 -
                $signed({2'b0, slice_number_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= xs;
            y_reg   <= ys;
            z_reg   <= zs;
            out_reg <= (xs < 0) || (xs >= $signed({2'b0, grid_cols_reg})) ||
                       (ys < 0) || (ys >= $signed({2'b0, grid_rows_reg})) ||
                       (zs < 0) || (zs >= $signed({2'b0, grid_slices_reg}));
            zgc_reg  <= 24'(z_reg[11:0] * grid_cols_reg);
            ygc_reg  <= 24'(y_reg[11:0] * grid_cols_reg);
            xa_reg   <= x_reg[11:0];
            out2_reg <= out_reg;
            plane_reg <= 36'(zgc_reg * grid_rows_reg);
            xa2_reg  <= 12'(ygc_reg[11:0]) ^ 12'(ygc_reg[11:0]) ^ xa_reg;
            out3_reg <= out2_reg;
        end
    end

    logic [23:0] ygc2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ygc2_reg <= ygc_reg;
            addr_reg <= out3_reg ? 36'd0 :
                        plane_reg + 36'(ygc2_reg) + 36'(xa2_reg);
        end
    end

    // The outside flag is delayed one more stage to sit beside the address.
    logic out4_reg;
    always_ff @(posedge aclk) if (en) out4_reg <= out3_reg;

    localparam int DLY = LAT - 4;
    logic [36:0] dly_reg [DLY+1];
    always_comb dly_reg[0] = {out4_reg, addr_reg};
    for (genvar k = 0; k < DLY; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) dly_reg[k+1] <= dly_reg[k];
        end
    end

    // dly_reg taps: addr stage is 4 deep, quaternion is LAT deep.
    logic [36:0] place_w;
    logic        out_d;
    assign place_w = dly_reg[DLY];
    assign out_d = place_w[36];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {3'd0, q4, q3, q2, q1, out_d, place_w[35:0]};
        end
    end

    logic unused_ok;
    assign unused_ok = ^{s_tdata[87:81]};

endmodule
`default_nettype wire

// ===== hdl/eqvp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eqvp_checker
// Port-level checks for the voxel placer, attached by bind.
// ----------------------------------------------------------------------------
module eqvp_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [111:0] m_tdata
);

    // A stalled result keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // The input side stalls exactly while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // An outside point always carries address zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> m_tdata[35:0] == 36'd0)
        else $error("outside point with nonzero address");

    // The first quaternion part stays within plus or minus one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[54:37]) <= 18'sd65536 &&
                     $signed(m_tdata[54:37]) >= -18'sd65536)
        else $error("quaternion part out of range");

endmodule

bind euler_to_quaternion_voxel_placer eqvp_checker u_eqvp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire
